@@ hw/rtl/fit_pkg.sv @@
`default_nettype none

package fit_pkg;

   localparam int TIME_BITS = 48;
   localparam int FRAC_BITS = 8;
   localparam int LOST_BITS = 16;
   localparam int FPS_BITS = 8;
   localparam int DUR_BITS = 17;

   localparam longint unsigned MICROS_PER_SEC = 64'd1000000;
   localparam longint unsigned PROF_NUM = MICROS_PER_SEC << FRAC_BITS;
   localparam int DEFAULT_FPS = 60;
   localparam int SLOW_FPS = 15;
   localparam longint unsigned SLOWEST_VALUE = (PROF_NUM + SLOW_FPS / 2) / SLOW_FPS;
   localparam longint unsigned RESET_VALUE = (PROF_NUM + DEFAULT_FPS / 2) / DEFAULT_FPS;

   localparam int PERIOD_BITS = $clog2(SLOWEST_VALUE + 1);
   localparam int RAW_CAP_SHIFT = 30 + FRAC_BITS;
   localparam int RAW_BITS = RAW_CAP_SHIFT + 1;

   localparam int DIVIDEND_BITS = TIME_BITS + FRAC_BITS;
   localparam int DIVISOR_BITS = LOST_BITS + 1;
   localparam int ITEM_ITERS = (DIVIDEND_BITS + 1) / 2;
   localparam int QUO_BITS = 2 * ITEM_ITERS;
   localparam int PROF_BITS = $clog2(PROF_NUM + (1 << FPS_BITS));
   localparam int PROF_ITERS = (PROF_BITS + 1) / 2;
   localparam int ITER_BITS = $clog2(ITEM_ITERS + 1);

   localparam logic [PERIOD_BITS-1:0] SLOWEST_PERIOD = PERIOD_BITS'(SLOWEST_VALUE);
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = PERIOD_BITS'(RESET_VALUE);
   localparam logic [RAW_BITS-1:0] RAW_CAP = RAW_BITS'(1) << RAW_CAP_SHIFT;

   typedef struct packed {
      logic start;
      logic [QUO_BITS-1:0] numer;
      logic [DIVISOR_BITS-1:0] divisor;
      logic [ITER_BITS-1:0] iters;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [QUO_BITS-1:0] quotient;
   } div_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/fit_req_if.sv @@
`default_nettype none

interface fit_req_if;
   logic valid;
   logic ready;
   logic [fit_pkg::TIME_BITS-1:0] arrival_time_us;
   logic [fit_pkg::LOST_BITS-1:0] lost_frames;

   modport source(output valid, output arrival_time_us, output lost_frames, input ready);
   modport sink(input valid, input arrival_time_us, input lost_frames, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fit_rsp_if.sv @@
`default_nettype none

interface fit_rsp_if;
   logic valid;
   logic ready;
   logic [fit_pkg::TIME_BITS-1:0] packet_pts;
   logic [fit_pkg::DUR_BITS-1:0] packet_duration_us;

   modport source(output valid, output packet_pts, output packet_duration_us, input ready);
   modport sink(input valid, input packet_pts, input packet_duration_us, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fit_divider.sv @@
`default_nettype none

// Restoring divider that retires two quotient bits per cycle.
module fit_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fit_pkg::div_cmd_type cmd,
   output fit_pkg::div_sts_type      sts
);

   localparam int TRIAL_BITS = fit_pkg::DIVISOR_BITS + 1;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [fit_pkg::ITER_BITS-1:0] count_ff, count_in;
   logic [fit_pkg::QUO_BITS-1:0] numer_ff, numer_in;
   logic [fit_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic [fit_pkg::DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [fit_pkg::DIVISOR_BITS-1:0] divisor_ff, divisor_in;

   logic [TRIAL_BITS-1:0] trial_hi, trial_lo, divisor_ext;
   logic [fit_pkg::DIVISOR_BITS-1:0] rem_mid;
   logic bit_hi, bit_lo;

   always_comb begin
      divisor_ext = {1'b0, divisor_ff};
      trial_hi = {rem_ff, numer_ff[fit_pkg::QUO_BITS-1]};
      bit_hi = (trial_hi >= divisor_ext);
      rem_mid = bit_hi ? fit_pkg::DIVISOR_BITS'(trial_hi - divisor_ext)
                       : trial_hi[fit_pkg::DIVISOR_BITS-1:0];
      trial_lo = {rem_mid, numer_ff[fit_pkg::QUO_BITS-2]};
      bit_lo = (trial_lo >= divisor_ext);

      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      numer_in = numer_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         count_in = cmd.iters;
         numer_in = cmd.numer;
         quo_in = '0;
         rem_in = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         numer_in = {numer_ff[fit_pkg::QUO_BITS-3:0], 2'b00};
         quo_in = {quo_ff[fit_pkg::QUO_BITS-3:0], bit_hi, bit_lo};
         rem_in = bit_lo ? fit_pkg::DIVISOR_BITS'(trial_lo - divisor_ext)
                         : trial_lo[fit_pkg::DIVISOR_BITS-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == fit_pkg::ITER_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      numer_ff <= numer_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign sts.done = done_ff;
   assign sts.quotient = quo_ff;

   property p_done_ends_run;
      @(posedge clock) disable iff (reset)
         done_ff |-> !busy_ff && $past(busy_ff) && !$past(cmd.start);
   endproperty
   a_done_ends_run: assert property (p_done_ends_run)
      else $error("divider done without a finished run");

   property p_count_live;
      @(posedge clock) disable iff (reset)
         busy_ff |-> count_ff != '0;
   endproperty
   a_count_live: assert property (p_count_live)
      else $error("divider busy with an empty count");

   property p_remainder_bound;
      @(posedge clock) disable iff (reset)
         busy_ff && !$past(cmd.start) |-> rem_ff < divisor_ff;
   endproperty
   a_remainder_bound: assert property (p_remainder_bound)
      else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

@@ hw/rtl/frame_interval_tracker.sv @@
// Tracks the frame period of a video stream from sample arrival times and emits a
// synthetic timestamp and a rounded duration for every request. A request that
// follows an earlier one runs the shared radix-4 divider through the 56-bit scaled
// gap before its result is presented; the first request after reset skips the
// divider. A new request is taken only once the previous result has been moved to
// the output register, and can be taken in the cycle in which that result appears.
// A write of the profile rate reruns the divider on the new rate and holds the
// request side off until the divider is done. The result sits in an output register,
// so a new request is accepted while the previous result waits to be taken.
`default_nettype none

module frame_interval_tracker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   fit_req_if.sink                           req_chan,
   fit_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_write_enable,
   input  wire logic [fit_pkg::FPS_BITS-1:0] csr_write_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_PROF    = 4'd1;
   localparam logic [3:0] ST_GAP     = 4'd2;
   localparam logic [3:0] ST_DIVW    = 4'd3;
   localparam logic [3:0] ST_RECOVER = 4'd4;
   localparam logic [3:0] ST_ADOPT   = 4'd5;
   localparam logic [3:0] ST_MULT    = 4'd6;
   localparam logic [3:0] ST_ADD     = 4'd7;
   localparam logic [3:0] ST_EMIT    = 4'd8;

   localparam int TB = fit_pkg::TIME_BITS;
   localparam int PB = fit_pkg::PERIOD_BITS;
   localparam int RB = fit_pkg::RAW_BITS;
   localparam int LB = fit_pkg::LOST_BITS;
   localparam int DB = fit_pkg::DUR_BITS;
   localparam int PROD_BITS = DB + LB;
   localparam int REC_BITS = RB + 5;
   localparam int CMP_BITS = PB + 4;
   localparam int PROF_SHIFT = fit_pkg::QUO_BITS - 2 * fit_pkg::PROF_ITERS;

   logic [3:0] state_ff, state_in;
   logic have_prev_ff, have_prev_in;
   logic [TB-1:0] prev_arrival_ff, prev_arrival_in;
   logic [TB-1:0] next_pts_ff, next_pts_in;
   logic [PB-1:0] def_ff, def_in;
   logic [PB-1:0] frame_ff, frame_in;
   logic [PB-1:0] cand_ff, cand_in;
   logic [1:0] cand_hits_ff, cand_hits_in;
   logic [1:0] rec_hits_ff, rec_hits_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [TB-1:0] arrival_ff, arrival_in;
   logic [LB-1:0] lost_ff, lost_in;
   logic [RB-1:0] raw_ff, raw_in;
   logic [PB-1:0] obs_ff, obs_in;
   logic [DB-1:0] dur_ff, dur_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [TB-1:0] pts_ff, pts_in;
   logic [TB-1:0] out_pts_ff, out_pts_in;
   logic [DB-1:0] out_dur_ff, out_dur_in;

   fit_pkg::div_cmd_type div_cmd;
   fit_pkg::div_sts_type div_sts;

   logic [fit_pkg::FPS_BITS-1:0] fps_eff;
   logic [fit_pkg::PROF_BITS-1:0] prof_value;
   logic [2*fit_pkg::PROF_ITERS-1:0] prof_quo;
   logic [PB-1:0] prof_period;
   logic [TB-1:0] gap;
   logic [RB-1:0] raw_capped;
   logic [RB-1:0] def_wide;
   logic [RB-1:0] raw_diff;
   logic [REC_BITS-1:0] raw_diff_x20;
   logic recover_hit;
   logic [1:0] rec_next;
   logic [PB-1:0] cand_diff, frame_diff;
   logic [CMP_BITS-1:0] cand_diff_x10, frame_diff_x5;
   logic cand_close, cur_far;
   logic [1:0] hits_next;
   logic [PB-1:0] cand_next;
   logic [PB:0] dur_round;
   logic [DB-1:0] dur_calc;
   logic req_take, out_free;

   fit_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_write_enable;
   assign req_take = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      fps_eff = (csr_write_data == '0) ? fit_pkg::FPS_BITS'(fit_pkg::DEFAULT_FPS)
                                       : csr_write_data;
      prof_value = fit_pkg::PROF_BITS'(fit_pkg::PROF_NUM)
                 + fit_pkg::PROF_BITS'(fps_eff >> 1);
      prof_quo = div_sts.quotient[2*fit_pkg::PROF_ITERS-1:0];
      prof_period = (prof_quo > (2*fit_pkg::PROF_ITERS)'(fit_pkg::SLOWEST_PERIOD))
                  ? fit_pkg::SLOWEST_PERIOD : PB'(prof_quo);

      gap = (arrival_ff >= prev_arrival_ff) ? arrival_ff - prev_arrival_ff : '0;
      raw_capped = (div_sts.quotient >= fit_pkg::QUO_BITS'(fit_pkg::RAW_CAP))
                 ? fit_pkg::RAW_CAP : div_sts.quotient[RB-1:0];

      def_wide = RB'(def_ff);
      raw_diff = (raw_ff >= def_wide) ? raw_ff - def_wide : def_wide - raw_ff;
      raw_diff_x20 = REC_BITS'(raw_diff) * REC_BITS'(20);
      recover_hit = (frame_ff > def_ff) && (raw_diff_x20 <= REC_BITS'(def_ff));
      rec_next = rec_hits_ff + 2'd1;

      cand_diff = (obs_ff >= cand_ff) ? obs_ff - cand_ff : cand_ff - obs_ff;
      frame_diff = (obs_ff >= frame_ff) ? obs_ff - frame_ff : frame_ff - obs_ff;
      cand_diff_x10 = CMP_BITS'(cand_diff) * CMP_BITS'(10);
      frame_diff_x5 = CMP_BITS'(frame_diff) * CMP_BITS'(5);
      cand_close = (cand_ff != '0) && (cand_diff_x10 <= CMP_BITS'(cand_ff));
      cur_far = (frame_ff == '0) || (frame_diff_x5 >= CMP_BITS'(frame_ff));
      hits_next = cand_close ? cand_hits_ff + 2'd1 : 2'd1;
      cand_next = cand_close ? cand_ff : obs_ff;

      dur_round = (PB + 1)'(frame_ff) + (PB + 1)'(1 << (fit_pkg::FRAC_BITS - 1));
      dur_calc = dur_round[fit_pkg::FRAC_BITS +: DB];
      if (dur_calc == '0) begin
         dur_calc = DB'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      have_prev_in = have_prev_ff;
      prev_arrival_in = prev_arrival_ff;
      next_pts_in = next_pts_ff;
      def_in = def_ff;
      frame_in = frame_ff;
      cand_in = cand_ff;
      cand_hits_in = cand_hits_ff;
      rec_hits_in = rec_hits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      arrival_in = arrival_ff;
      lost_in = lost_ff;
      raw_in = raw_ff;
      obs_in = obs_ff;
      dur_in = dur_ff;
      prod_in = prod_ff;
      pts_in = pts_ff;
      out_pts_in = out_pts_ff;
      out_dur_in = out_dur_ff;

      div_cmd.start = 1'b0;
      div_cmd.numer = {gap, fit_pkg::FRAC_BITS'(0)};
      div_cmd.divisor = fit_pkg::DIVISOR_BITS'(lost_ff) + fit_pkg::DIVISOR_BITS'(1);
      div_cmd.iters = fit_pkg::ITER_BITS'(fit_pkg::ITEM_ITERS);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               arrival_in = req_chan.arrival_time_us;
               lost_in = req_chan.lost_frames;
               state_in = have_prev_ff ? ST_GAP : ST_MULT;
            end
         end
         ST_PROF: begin
            if (div_sts.done) begin
               def_in = prof_period;
               frame_in = prof_period;
               cand_in = prof_period;
               state_in = ST_IDLE;
            end
         end
         ST_GAP: begin
            div_cmd.start = 1'b1;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_sts.done) begin
               raw_in = raw_capped;
               state_in = ST_RECOVER;
            end
         end
         ST_RECOVER: begin
            if (raw_ff < def_wide) begin
               obs_in = def_ff;
            end else if (raw_ff > RB'(fit_pkg::SLOWEST_PERIOD)) begin
               obs_in = fit_pkg::SLOWEST_PERIOD;
            end else begin
               obs_in = raw_ff[PB-1:0];
            end
            if (recover_hit) begin
               if (rec_next == 2'd3) begin
                  frame_in = def_ff;
                  cand_in = def_ff;
                  cand_hits_in = 2'd0;
                  rec_hits_in = 2'd0;
               end else begin
                  rec_hits_in = rec_next;
               end
            end else begin
               rec_hits_in = 2'd0;
            end
            state_in = ST_ADOPT;
         end
         ST_ADOPT: begin
            if (cur_far) begin
               if (hits_next == 2'd3) begin
                  frame_in = cand_next;
                  cand_hits_in = 2'd0;
               end else begin
                  cand_hits_in = hits_next;
               end
               cand_in = cand_next;
            end else begin
               cand_in = frame_ff;
               cand_hits_in = 2'd0;
            end
            state_in = ST_MULT;
         end
         ST_MULT: begin
            dur_in = dur_calc;
            prod_in = dur_calc * lost_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            pts_in = next_pts_ff + TB'(prod_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pts_in = pts_ff;
               out_dur_in = dur_ff;
               next_pts_in = pts_ff + TB'(dur_ff);
               prev_arrival_in = arrival_ff;
               have_prev_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         div_cmd.start = 1'b1;
         div_cmd.numer = fit_pkg::QUO_BITS'(prof_value) << PROF_SHIFT;
         div_cmd.divisor = fit_pkg::DIVISOR_BITS'(fps_eff);
         div_cmd.iters = fit_pkg::ITER_BITS'(fit_pkg::PROF_ITERS);
         cand_hits_in = 2'd0;
         rec_hits_in = 2'd0;
         state_in = ST_PROF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_arrival_ff <= '0;
         next_pts_ff <= '0;
         def_ff <= fit_pkg::RESET_PERIOD;
         frame_ff <= fit_pkg::RESET_PERIOD;
         cand_ff <= fit_pkg::RESET_PERIOD;
         cand_hits_ff <= 2'd0;
         rec_hits_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_prev_ff <= have_prev_in;
         prev_arrival_ff <= prev_arrival_in;
         next_pts_ff <= next_pts_in;
         def_ff <= def_in;
         frame_ff <= frame_in;
         cand_ff <= cand_in;
         cand_hits_ff <= cand_hits_in;
         rec_hits_ff <= rec_hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      arrival_ff <= arrival_in;
      lost_ff <= lost_in;
      raw_ff <= raw_in;
      obs_ff <= obs_in;
      dur_ff <= dur_in;
      prod_ff <= prod_in;
      pts_ff <= pts_in;
      out_pts_ff <= out_pts_in;
      out_dur_ff <= out_dur_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.packet_pts = out_pts_ff;
   assign rsp_chan.packet_duration_us = out_dur_ff;

   property p_done_when_waiting;
      @(posedge clock) disable iff (reset)
         div_sts.done |-> state_ff == ST_DIVW || state_ff == ST_PROF;
   endproperty
   a_done_when_waiting: assert property (p_done_when_waiting)
      else $error("divider finished while the sequencer was not waiting");

   property p_period_range;
      @(posedge clock) disable iff (reset)
         frame_ff != '0 && frame_ff <= fit_pkg::SLOWEST_PERIOD
         && def_ff <= frame_ff;
   endproperty
   a_period_range: assert property (p_period_range)
      else $error("frame period left the profile to slowest range");

   property p_hits_below_three;
      @(posedge clock) disable iff (reset)
         cand_hits_ff != 2'd3 && rec_hits_ff != 2'd3;
   endproperty
   a_hits_below_three: assert property (p_hits_below_three)
      else $error("hit counter held three");

   property p_result_from_emit;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT && state_ff == ST_IDLE;
   endproperty
   a_result_from_emit: assert property (p_result_from_emit)
      else $error("result appeared outside the emit step");

endmodule

`default_nettype wire

@@ tb/sv/fit_timing_checker.sv @@
`default_nettype none

module fit_timing_checker
   import fit_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   fit_req_if                       req_chan,
   fit_rsp_if                       rsp_chan,
   input  wire logic                csr_write_enable,
   input  wire logic [FPS_BITS-1:0] csr_write_data,
   output int                       mismatches,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned GAP_CEIL_US = 64'd1 << 30;

   typedef struct packed {
      logic [TIME_BITS-1:0] pts;
      logic [DUR_BITS-1:0]  duration;
   } frame_timing_type;

   frame_timing_type expected_timing[$];

   logic [FPS_BITS-1:0]    rate_fps;
   logic                   seen_first;
   logic [TIME_BITS-1:0]   last_arrival;
   logic [TIME_BITS-1:0]   pts_cursor;
   logic [PERIOD_BITS-1:0] cur_period;
   logic [PERIOD_BITS-1:0] cand_period;
   logic [1:0]             cand_hits;
   logic [1:0]             settle_hits;

   function automatic longint unsigned profile_period_of(input logic [FPS_BITS-1:0] fps);
      longint unsigned rate;
      longint unsigned period;
      rate = (fps == 0) ? DEFAULT_FPS : fps;
      period = (PROF_NUM + rate / 2) / rate;
      return (period > SLOWEST_VALUE) ? SLOWEST_VALUE : period;
   endfunction

   function automatic longint unsigned distance(input longint unsigned a,
                                                input longint unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic reload_periods();
      cur_period = PERIOD_BITS'(profile_period_of(rate_fps));
      cand_period = cur_period;
      cand_hits = 2'd0;
      settle_hits = 2'd0;
   endtask

   task automatic track_sample(input logic [TIME_BITS-1:0] arrival,
                               input logic [LOST_BITS-1:0] lost);
      longint unsigned  gap;
      longint unsigned  divisor;
      longint unsigned  quo;
      longint unsigned  rem;
      longint unsigned  raw;
      longint unsigned  obs;
      longint unsigned  nominal;
      longint unsigned  duration;
      logic             cand_close;
      logic             cur_far;
      frame_timing_type want;
      if (seen_first) begin
         gap = (arrival >= last_arrival) ? arrival - last_arrival : 64'd0;
         divisor = lost + 64'd1;
         quo = gap / divisor;
         rem = gap % divisor;
         if (quo >= GAP_CEIL_US) begin
            quo = GAP_CEIL_US;
            rem = 0;
         end
         raw = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / divisor);
         nominal = profile_period_of(rate_fps);
         if (raw < nominal)
            obs = nominal;
         else if (raw > SLOWEST_VALUE)
            obs = SLOWEST_VALUE;
         else
            obs = raw;

         // A slowed stream that runs at the nominal rate again returns to it.
         if (cur_period > nominal && distance(raw, nominal) * 20 <= nominal) begin
            settle_hits = settle_hits + 2'd1;
            if (settle_hits == 2'd3) begin
               cur_period = PERIOD_BITS'(nominal);
               cand_period = cur_period;
               cand_hits = 2'd0;
               settle_hits = 2'd0;
            end
         end else begin
            settle_hits = 2'd0;
         end

         cand_close = cand_period != 0 && distance(obs, cand_period) * 10 <= cand_period;
         cur_far = cur_period == 0 || distance(obs, cur_period) * 5 >= cur_period;
         if (cur_far) begin
            if (cand_close) begin
               cand_hits = cand_hits + 2'd1;
            end else begin
               cand_period = PERIOD_BITS'(obs);
               cand_hits = 2'd1;
            end
            if (cand_hits == 2'd3) begin
               cur_period = cand_period;
               cand_hits = 2'd0;
            end
         end else begin
            cand_period = cur_period;
            cand_hits = 2'd0;
         end
      end
      last_arrival = arrival;
      seen_first = 1'b1;

      duration = (cur_period + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (duration < 1)
         duration = 1;
      if (lost != 0)
         pts_cursor = pts_cursor + TIME_BITS'(duration * lost);
      want.pts = pts_cursor;
      want.duration = DUR_BITS'(duration);
      expected_timing.push_back(want);
      pts_cursor = pts_cursor + TIME_BITS'(duration);
   endtask

   always @(posedge clock) begin : watch
      frame_timing_type want;
      if (reset) begin
         rate_fps = FPS_BITS'(DEFAULT_FPS);
         seen_first = 1'b0;
         last_arrival = '0;
         pts_cursor = '0;
         reload_periods();
         expected_timing.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_timing.size() == 0) begin
               $error("unexpected result: packet_pts %0d, packet_duration_us %0d",
                      rsp_chan.packet_pts, rsp_chan.packet_duration_us);
               mismatches++;
            end else begin
               want = expected_timing.pop_front();
               if (rsp_chan.packet_pts !== want.pts) begin
                  $error("packet_pts: expected %0d, actual %0d",
                         want.pts, rsp_chan.packet_pts);
                  mismatches++;
               end
               if (rsp_chan.packet_duration_us !== want.duration) begin
                  $error("packet_duration_us: expected %0d, actual %0d",
                         want.duration, rsp_chan.packet_duration_us);
                  mismatches++;
               end
            end
         end
         if (csr_write_enable) begin
            rate_fps = csr_write_data;
            reload_periods();
         end
         if (req_chan.valid && req_chan.ready)
            track_sample(req_chan.arrival_time_us, req_chan.lost_frames);
      end
      pending = expected_timing.size();
   end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fit_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 108;
   localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [FPS_BITS-1:0]  csr_write_data;
   int                   mismatches;
   int                   pending;
   int                   send_idle_pct = 19;
   int                   recv_idle_pct = 48;
   int                   quiet_cycles = 0;
   logic [TIME_BITS-1:0] stream_time_us;
   longint unsigned      nominal_us;

   fit_req_if req_chan();
   fit_rsp_if rsp_chan();

   frame_interval_tracker DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   fit_timing_checker timing_watch (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic longint unsigned nominal_gap_us(input logic [FPS_BITS-1:0] fps);
      longint unsigned rate;
      rate = (fps == 0) ? DEFAULT_FPS : fps;
      return (1000000 / rate > 66667) ? 66667 : 1000000 / rate;
   endfunction

   function automatic logic [FPS_BITS-1:0] profile_for(input int phase);
      case (phase)
         0: return 8'd0;
         1: return 8'd240;
         2: return 8'd1;
         3: return 8'd255;
         4: return 8'd15;
         5: return 8'd14;
         6: return 8'd16;
         7: return 8'd30;
         8: return 8'd120;
         default: return 8'd60;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_sample(input logic [TIME_BITS-1:0] arrival,
                              input logic [LOST_BITS-1:0] lost);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.arrival_time_us <= arrival;
      req_chan.lost_frames <= lost;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic program_profile(input logic [FPS_BITS-1:0] fps);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= fps;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      nominal_us = nominal_gap_us(fps);
   endtask

   task automatic send_noise();
      logic [TIME_BITS-1:0] arrival;
      logic [LOST_BITS-1:0] lost;
      case ($urandom_range(3))
         0: begin
            arrival = TIME_BITS'({$urandom, $urandom});
            lost = LOST_BITS'($urandom);
         end
         1: begin
            arrival = stream_time_us - $urandom_range(1, 200000);
            lost = '0;
         end
         2: begin
            arrival = stream_time_us + TIME_BITS'({$urandom_range(1, 65535), $urandom});
            lost = LOST_BITS'($urandom_range(3));
         end
         default: begin
            arrival = stream_time_us + TIME_BITS'(nominal_us * $urandom_range(1, 40));
            lost = LOST_BITS'($urandom);
         end
      endcase
      stream_time_us = arrival;
      send_sample(arrival, lost);
   endtask

   // Mostly bursts at one frame rate, so that new periods get adopted and dropped again.
   task automatic play_stream(input int total);
      int              sent;
      int              burst;
      int              mode;
      int              k;
      int              lost_n;
      longint unsigned step_us;
      sent = 0;
      while (sent < total) begin
         mode = $urandom_range(99);
         if (mode < 12) begin
            send_noise();
            sent++;
         end else begin
            burst = $urandom_range(3, 12);
            if (mode < 45)
               step_us = nominal_us;
            else if (mode < 75)
               step_us = nominal_us * $urandom_range(130, 300) / 100;
            else if (mode < 85)
               step_us = nominal_us * $urandom_range(40, 95) / 100;
            else
               step_us = nominal_us * $urandom_range(104, 125) / 100;
            for (k = 0; k < burst && sent < total; k++) begin
               lost_n = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 0;
               stream_time_us = stream_time_us + TIME_BITS'(
                  step_us * (lost_n + 1) * $urandom_range(980, 1020) / 1000);
               send_sample(stream_time_us, LOST_BITS'(lost_n));
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.arrival_time_us = '0;
      req_chan.lost_frames = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      stream_time_us = '0;
      nominal_us = nominal_gap_us(FPS_BITS'(DEFAULT_FPS));
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_sample(48'd0, 16'd0);
      send_sample(48'd16667, 16'd0);
      send_sample(48'd33333, 16'd0);
      send_sample(48'd83333, 16'd2);
      send_sample(48'd88333, 16'd0);
      send_sample(48'd50, 16'd0);
      send_sample(48'd33383, 16'd0);
      send_sample(48'd66716, 16'd0);
      send_sample(48'd100049, 16'd0);
      send_sample(48'd133382, 16'd0);
      send_sample(48'd150049, 16'd0);
      send_sample(48'd166716, 16'd0);
      send_sample(48'd183383, 16'd0);
      send_sample(48'd200050, 16'd0);
      send_sample(TIME_ALL_ONES, 16'd0);
      send_sample(TIME_ALL_ONES, 16'hFFFF);
      send_sample(48'd0, 16'hFFFF);
      send_sample(TIME_ALL_ONES, 16'hFFFF);
      send_sample(48'hAAAA_AAAA_AAAA, 16'h5555);
      send_sample(48'h5555_5555_5555, 16'hAAAA);
      stream_time_us = 48'h5555_5555_5555;

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 19;
         end else if (phase == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_profile(profile_for(phase));
         play_stream(PHASE_ITEMS);
      end

      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
